>>> src/array_linked_list_engine_defines.svh
// assertion macros for the array linked list engine
// used by the top level; expects clk and arst_n in scope
`ifndef ARRAY_LINKED_LIST_ENGINE_DEFINES_SVH
`define ARRAY_LINKED_LIST_ENGINE_DEFINES_SVH
`ifndef ASSERT_OFF
`define ALLE_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define ALLE_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`else
`define ALLE_ASSERT(label, prop, msg)
`define ALLE_NEVER(label, expr, msg)
`endif
`endif

>>> src/alle_pkg.sv
// shared types, codes and sizes of the array linked list engine
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package alle_pkg;
	localparam int CAP = 128;
	localparam int IDX_W = $clog2(CAP);
	localparam int NODE_W = IDX_W + 1;
	localparam logic [NODE_W-1:0] NODE_NONE = NODE_W'(CAP);

	localparam logic [2:0] REQ_ADD_FRONT = 3'd0;
	localparam logic [2:0] REQ_ADD_END   = 3'd1;
	localparam logic [2:0] REQ_INSERT    = 3'd2;
	localparam logic [2:0] REQ_REMOVE    = 3'd3;
	localparam logic [2:0] REQ_GET       = 3'd4;
	localparam logic [2:0] REQ_SET       = 3'd5;
	localparam logic [2:0] REQ_SEARCH    = 3'd6;
	localparam logic [2:0] REQ_FIRST     = 3'd7;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_BAD_POS = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;

	localparam logic [4:0] OP_NONE       = 5'd0;
	localparam logic [4:0] OP_LATCH      = 5'd1;
	localparam logic [4:0] OP_WALK_INIT  = 5'd2;
	localparam logic [4:0] OP_WALK_STEP  = 5'd3;
	localparam logic [4:0] OP_RD_FREE    = 5'd4;
	localparam logic [4:0] OP_ADD_FRONT  = 5'd5;
	localparam logic [4:0] OP_ADD_END    = 5'd6;
	localparam logic [4:0] OP_TAIL_LINK  = 5'd7;
	localparam logic [4:0] OP_GET        = 5'd8;
	localparam logic [4:0] OP_SET        = 5'd9;
	localparam logic [4:0] OP_RM_A       = 5'd10;
	localparam logic [4:0] OP_RM_B       = 5'd11;
	localparam logic [4:0] OP_INS_A      = 5'd12;
	localparam logic [4:0] OP_INS_B      = 5'd13;
	localparam logic [4:0] OP_INS_C      = 5'd14;
	localparam logic [4:0] OP_SEARCH_HIT = 5'd15;
	localparam logic [4:0] OP_RES        = 5'd16;
	localparam logic [4:0] OP_FIRST      = 5'd17;
	localparam logic [4:0] OP_LOAD_OUT   = 5'd18;

	typedef struct packed {
		logic [4:0] op;
		logic [1:0] code;
	} cmd_t;

	typedef struct packed {
		logic [2:0] req;
		logic       full;
		logic       head_none;
		logic       at_end;
		logic       hit_pos;
		logic       hit_val;
		logic       tail;
		logic       steps_max;
		logic       out_busy;
	} sts_t;
endpackage
`default_nettype wire

>>> src/alle_ctrl.sv
// sequencer of the array linked list engine
// depends on alle_pkg; drives alle_datapath through cmd_t
`timescale 1ns / 1ps
`default_nettype none
module alle_ctrl import alle_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_DISP  = 4'd1;
	localparam logic [3:0] S_TAKE  = 4'd2;
	localparam logic [3:0] S_WINIT = 4'd3;
	localparam logic [3:0] S_WALK  = 4'd4;
	localparam logic [3:0] S_RM2   = 4'd5;
	localparam logic [3:0] S_INS2  = 4'd6;
	localparam logic [3:0] S_INS3  = 4'd7;
	localparam logic [3:0] S_FIN   = 4'd8;

	logic [3:0] state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd.op = OP_NONE;
		cmd.code = ST_OK;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op = OP_LATCH;
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				state_d = S_FIN;
				case (sts.req)
					REQ_ADD_FRONT, REQ_ADD_END: begin
						if (sts.full) begin
							cmd.op = OP_RES;
							cmd.code = ST_FULL;
						end else begin
							cmd.op = OP_RD_FREE;
							state_d = S_TAKE;
						end
					end
					REQ_INSERT: begin
						if (sts.full) begin
							cmd.op = OP_RES;
							cmd.code = ST_FULL;
						end else begin
							cmd.op = OP_WALK_INIT;
							state_d = S_WALK;
						end
					end
					REQ_REMOVE, REQ_GET, REQ_SET, REQ_SEARCH: begin
						cmd.op = OP_WALK_INIT;
						state_d = S_WALK;
					end
					default: begin
						cmd.op = OP_FIRST;
					end
				endcase
			end
			S_TAKE: begin
				state_d = S_FIN;
				if (sts.req == REQ_ADD_FRONT) begin
					cmd.op = OP_ADD_FRONT;
				end else begin
					cmd.op = OP_ADD_END;
					if (!sts.head_none) state_d = S_WINIT;
				end
			end
			S_WINIT: begin
				cmd.op = OP_WALK_INIT;
				state_d = S_WALK;
			end
			S_WALK: begin
				cmd.op = OP_WALK_STEP;
				if (sts.req == REQ_ADD_END) begin
					if (sts.tail || sts.steps_max) begin
						cmd.op = OP_TAIL_LINK;
						state_d = S_FIN;
					end
				end else if (sts.at_end) begin
					state_d = S_FIN;
					if (sts.req == REQ_SEARCH) begin
						cmd.op = OP_NONE;
					end else begin
						cmd.op = OP_RES;
						cmd.code = ST_BAD_POS;
					end
				end else if (sts.req == REQ_SEARCH) begin
					if (sts.hit_val) begin
						cmd.op = OP_SEARCH_HIT;
						state_d = S_FIN;
					end
				end else if (sts.hit_pos) begin
					case (sts.req)
						REQ_REMOVE: begin
							cmd.op = OP_RM_A;
							state_d = S_RM2;
						end
						REQ_INSERT: begin
							cmd.op = OP_INS_A;
							state_d = S_INS2;
						end
						REQ_SET: begin
							cmd.op = OP_SET;
							state_d = S_FIN;
						end
						default: begin
							cmd.op = OP_GET;
							state_d = S_FIN;
						end
					endcase
				end
			end
			S_RM2: begin
				cmd.op = OP_RM_B;
				state_d = S_FIN;
			end
			S_INS2: begin
				cmd.op = OP_INS_B;
				state_d = S_INS3;
			end
			S_INS3: begin
				cmd.op = OP_INS_C;
				state_d = S_FIN;
			end
			S_FIN: begin
				if (!sts.out_busy) begin
					cmd.op = OP_LOAD_OUT;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end
endmodule
`default_nettype wire

>>> src/alle_datapath.sv
// node tables, list pointers, walk registers and result register
// depends on alle_pkg; commanded by alle_ctrl
`timescale 1ns / 1ps
`default_nettype none
module alle_datapath import alle_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	output sts_t               sts,
	input  logic [2:0]         in_req,
	input  logic [7:0]         in_pos,
	input  logic [31:0]        in_val,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         out_status,
	output logic [31:0]        out_val,
	output logic [7:0]         out_pos,
	output logic [7:0]         out_cnt,
	output logic               out_empty
);
	logic [31:0]       vmem [CAP];
	logic [NODE_W-1:0] lmem [CAP];
	logic [CAP-1:0]    lvld_q;

	logic [2:0]        req_q;
	logic [7:0]        pos_q;
	logic [31:0]       val_q;
	logic [NODE_W-1:0] head_q, free_q, cur_q, prev_q, n_q, succ_q;
	logic [NODE_W:0]   count_q, steps_q;
	logic [31:0]       vrd_q;
	logic [NODE_W-1:0] lrd_q;
	logic [1:0]        res_status_q;
	logic [31:0]       res_val_q;
	logic [NODE_W-1:0] res_pos_q;
	logic              out_valid_q;

	logic [NODE_W-1:0] raddr_node;
	logic [IDX_W-1:0]  raddr;
	logic              lwr_en, vwr_en;
	logic [IDX_W-1:0]  lwr_addr, vwr_addr;
	logic [NODE_W-1:0] lwr_data;

	always_comb begin
		raddr_node = head_q;
		lwr_en = 1'b0;
		lwr_addr = free_q[IDX_W-1:0];
		lwr_data = NODE_NONE;
		vwr_en = 1'b0;
		vwr_addr = free_q[IDX_W-1:0];
		case (cmd.op)
			OP_WALK_STEP: raddr_node = lrd_q;
			OP_RD_FREE, OP_INS_A: raddr_node = free_q;
			OP_ADD_FRONT: begin
				lwr_en = 1'b1;
				lwr_data = head_q;
				vwr_en = 1'b1;
			end
			OP_ADD_END: begin
				lwr_en = 1'b1;
				vwr_en = 1'b1;
			end
			OP_TAIL_LINK, OP_INS_C: begin
				lwr_en = 1'b1;
				lwr_addr = cur_q[IDX_W-1:0];
				lwr_data = n_q;
			end
			OP_SET: begin
				vwr_en = 1'b1;
				vwr_addr = cur_q[IDX_W-1:0];
			end
			OP_RM_A: begin
				// unlink from predecessor, or from head when there is none
				lwr_en = !prev_q[IDX_W];
				lwr_addr = prev_q[IDX_W-1:0];
				lwr_data = lrd_q;
			end
			OP_RM_B: begin
				lwr_en = 1'b1;
				lwr_addr = cur_q[IDX_W-1:0];
				lwr_data = free_q;
			end
			OP_INS_B: begin
				lwr_en = 1'b1;
				lwr_data = succ_q;
				vwr_en = 1'b1;
			end
			default: begin
			end
		endcase
		raddr = raddr_node[IDX_W-1:0];
	end

	// node tables, registered read
	always_ff @(posedge clk) begin
		if (vwr_en) vmem[vwr_addr] <= val_q;
		if (lwr_en) lmem[lwr_addr] <= lwr_data;
		vrd_q <= vmem[raddr];
		lrd_q <= lvld_q[raddr] ? lmem[raddr] : NODE_W'({1'b0, raddr} + 1'b1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lvld_q <= '0;
			head_q <= NODE_NONE;
			free_q <= '0;
			count_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (lwr_en) lvld_q[lwr_addr] <= 1'b1;
			case (cmd.op)
				OP_ADD_FRONT: begin
					head_q <= free_q;
					free_q <= lrd_q;
					count_q <= count_q + 1'b1;
				end
				OP_ADD_END, OP_INS_B: begin
					if (cmd.op == OP_ADD_END && head_q[IDX_W]) head_q <= free_q;
					free_q <= lrd_q;
					count_q <= count_q + 1'b1;
				end
				OP_RM_A: begin
					if (prev_q[IDX_W]) head_q <= lrd_q;
				end
				OP_RM_B: begin
					free_q <= cur_q;
					count_q <= count_q - 1'b1;
				end
				default: begin
				end
			endcase
			if (cmd.op == OP_LOAD_OUT) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LATCH: begin
				req_q <= in_req;
				pos_q <= in_pos;
				val_q <= in_val;
				res_status_q <= ST_OK;
				res_val_q <= '0;
				res_pos_q <= NODE_NONE;
			end
			OP_WALK_INIT: begin
				cur_q <= head_q;
				prev_q <= NODE_NONE;
				steps_q <= '0;
			end
			OP_WALK_STEP: begin
				cur_q <= lrd_q;
				prev_q <= cur_q;
				steps_q <= steps_q + 1'b1;
			end
			OP_ADD_FRONT, OP_ADD_END, OP_INS_B: begin
				n_q <= free_q;
				res_pos_q <= free_q;
			end
			OP_GET, OP_SET: begin
				res_val_q <= vrd_q;
				res_pos_q <= cur_q;
			end
			OP_SEARCH_HIT: res_pos_q <= cur_q;
			OP_RM_A: begin
				res_val_q <= vrd_q;
				res_pos_q <= lrd_q;
			end
			OP_INS_A: succ_q <= lrd_q;
			OP_RES: res_status_q <= cmd.code;
			OP_FIRST: res_pos_q <= head_q;
			OP_LOAD_OUT: begin
				out_status <= res_status_q;
				out_val <= res_val_q;
				out_pos <= 8'(res_pos_q);
				out_cnt <= 8'(count_q);
				out_empty <= head_q[IDX_W];
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;

	always_comb begin
		sts.req = req_q;
		sts.full = (count_q == (NODE_W+1)'(CAP)) || free_q[IDX_W];
		sts.head_none = head_q[IDX_W];
		sts.steps_max = (steps_q == (NODE_W+1)'(CAP));
		sts.at_end = cur_q[IDX_W] || sts.steps_max;
		sts.hit_pos = (8'(cur_q) == pos_q);
		sts.hit_val = (vrd_q == val_q);
		sts.tail = lrd_q[IDX_W];
		sts.out_busy = out_valid_q && !out_ready;
	end
endmodule
`default_nettype wire

>>> src/array_linked_list_engine.sv
// top level of the array linked list engine
// depends on alle_pkg, alle_ctrl, alle_datapath and the defines header
//
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  tuser: req_type; tdata: position, value
//  m_*      out  m_tvalid/m_tready  tuser: status; tdata: value, pos, count, empty
//
// one request at a time; first, add front and add end on an empty list need
// no walk; walking requests follow one link per cycle from the head over the
// registered link table read port
// reset clears the pointers and the link valid bits at once, no clearing pass
// a result waits in the output register while the next request is taken
`timescale 1ns / 1ps
`default_nettype none
`include "array_linked_list_engine_defines.svh"
module array_linked_list_engine import alle_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // position[7:0], value[39:8]
	input  logic [2:0]  s_tuser,  // req_type[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,  // result_value[31:0], result_position[39:32],
	                              // element_count[47:40], is_empty[48], zero fill
	output logic [1:0]  m_tuser   // status[1:0]
);
	cmd_t        cmd;
	sts_t        sts;
	logic [31:0] out_val;
	logic [7:0]  out_pos, out_cnt;
	logic        out_empty;

	// sequencer
	alle_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// node tables and pointers
	alle_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.in_req     (s_tuser),
		.in_pos     (s_tdata[7:0]),
		.in_val     (s_tdata[39:8]),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_status (m_tuser),
		.out_val    (out_val),
		.out_pos    (out_pos),
		.out_cnt    (out_cnt),
		.out_empty  (out_empty)
	);

	assign m_tdata = {7'b0, out_empty, out_cnt, out_pos, out_val};

	// an accepted transfer starts a request, so no second one right after
	`ALLE_ASSERT(a_one_at_a_time, s_tvalid && s_tready |=> !s_tready, "second request taken")
	// the empty flag agrees with the element count
	`ALLE_ASSERT(a_empty_count, m_tvalid |-> (m_tdata[48] == (m_tdata[47:40] == 8'd0)), "empty flag mismatch")
	// an error never reports a node
	`ALLE_ASSERT(a_err_none, m_tvalid && (m_tuser != ST_OK) |-> (m_tdata[39:32] == 8'(CAP)), "error with node")
	// the count never passes the table size
	`ALLE_NEVER(a_count_max, m_tvalid && (m_tdata[47:40] > 8'(CAP)), "count overflow")
endmodule
`default_nettype wire
